/* rtl/core/mre_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_pkg
// Shared widths, codes, byte constants and pipeline stage types of the mouse
// report encoder.
// ----------------------------------------------------------------------------
package mre_pkg;

  // Field widths.
  localparam int COORD_W = 13;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Largest window dimension that the clamp honors.
  localparam int MAX_DIM = 4096;
  localparam logic [COORD_W-1:0] DIM_LIMIT =
      (MAX_DIM > 8191) ? 13'd8191 : COORD_W'(MAX_DIM);

  // Event type codes.
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_TRACK_PRESS_ONLY    = 3'd0;
  localparam logic [2:0] REG_TRACK_PRESS_RELEASE = 3'd1;
  localparam logic [2:0] REG_TRACK_DRAG          = 3'd2;
  localparam logic [2:0] REG_TRACK_ANY_MOTION    = 3'd3;
  localparam logic [2:0] REG_ENCODE_UTF8         = 3'd4;
  localparam logic [2:0] REG_ENCODE_URXVT        = 3'd5;
  localparam logic [2:0] REG_ENCODE_SGR          = 3'd6;

  // Report bytes.
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UP_M   = 8'h4D;
  localparam logic [7:0] CH_LO_M   = 8'h6D;
  localparam logic [3:0] CH_DIGIT  = 4'h3;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] X10_SAT    = 8'hFF;

  // Report encodings, in rising priority.
  typedef enum logic [1:0] {
    ENC_X10,
    ENC_UTF8,
    ENC_URXVT,
    ENC_SGR
  } enc_e;

  // A run of report bytes; byte 0 goes out first.
  typedef struct packed {
    logic [127:0] data;
    logic [4:0]   len;
  } slot_t;

  // Stage 1: filtered, clamped and coded.
  typedef struct packed {
    logic               rep;
    logic               release_evt;
    enc_e               mode;
    logic [6:0]         bt_x10;
    logic [6:0]         bt_dec;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } s1_t;

  // Stage 2: first half of the decimal conversion.
  typedef struct packed {
    logic               rep;
    logic               release_evt;
    enc_e               mode;
    logic [6:0]         bt_x10;
    logic [7:0]         bt_bcd;
    logic [28:0]        col_acc;
    logic [28:0]        row_acc;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } s2_t;

  // Stage 3: decimal digits complete.
  typedef struct packed {
    logic               rep;
    logic               release_evt;
    enc_e               mode;
    logic [6:0]         bt_x10;
    logic [7:0]         bt_bcd;
    logic [15:0]        col_bcd;
    logic [15:0]        row_bcd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } s3_t;

  // Stage 4: report pieces merged in pairs.
  typedef struct packed {
    logic  rep;
    slot_t p;
    slot_t q;
    slot_t r;
    slot_t t;
  } s4_t;

  // Stage 5: two halves of the report.
  typedef struct packed {
    logic  rep;
    slot_t pq;
    slot_t rt;
  } s5_t;

  // Stage 6: whole report.
  typedef struct packed {
    logic  rep;
    slot_t all;
  } s6_t;

endpackage

/* rtl/core/mre_evt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_evt_if
// Input channel of the mouse report encoder: one pointer event per item.
// ----------------------------------------------------------------------------
interface mre_evt_if import mre_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic [1:0]                event_type;
  logic [1:0]                button;
  logic                      captured;
  logic signed [COORD_W-1:0] row;
  logic signed [COORD_W-1:0] col;
  logic                      shift_held;
  logic                      meta_held;
  logic                      ctrl_held;
  logic [COORD_W-1:0]        visible_rows;
  logic [COORD_W-1:0]        visible_cols;

  modport source (
    output valid, event_type, button, captured, row, col,
           shift_held, meta_held, ctrl_held, visible_rows, visible_cols,
    input  ready
  );

  modport sink (
    input  valid, event_type, button, captured, row, col,
           shift_held, meta_held, ctrl_held, visible_rows, visible_cols,
    output ready
  );

endinterface

/* rtl/core/mre_rpt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_rpt_if
// Output channel of the mouse report encoder: one report byte per item.
// ----------------------------------------------------------------------------
interface mre_rpt_if import mre_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              reported;
  logic              last;

  modport source (
    output valid, out_byte, reported, last,
    input  ready
  );

  modport sink (
    input  valid, out_byte, reported, last,
    output ready
  );

endinterface

/* rtl/core/mouse_report_encoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_report_encoder_core
// Turns pointer events into xterm mouse reports (X10, UTF-8, urxvt, SGR),
// filtered by the tracking modes and given out one byte per item.
// ----------------------------------------------------------------------------
// Pipeline: an accepted event passes the stage registers s1 to s6 and then
// the output serializer, which gives one byte per cycle while the report side
// is ready; a report is 1 to 16 bytes long, and a new event enters every
// cycle while the six pipeline stages have room.
// Reset: rst_ni clears all tracking and encoding registers and empties the
// pipeline; the event channel is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module mouse_report_encoder_core import mre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  mre_evt_if.sink           evt_i,
  mre_rpt_if.source         rpt_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // --------------------------------------------------------------------------
  // Helper functions
  // --------------------------------------------------------------------------

  // Clamps a signed position into the window and makes it one-based.
  function automatic logic [COORD_W-1:0] clamp_pos(input logic [COORD_W-1:0] p,
                                                   input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] bnd;
    logic [COORD_W-1:0] v;
    bnd = (b > DIM_LIMIT) ? DIM_LIMIT : b;
    if (p[COORD_W-1]) begin
      v = '0;
    end else if (p >= bnd) begin
      v = (bnd == '0) ? '0 : bnd - COORD_W'(1);
    end else begin
      v = p;
    end
    return v + COORD_W'(1);
  endfunction

  // One shift-and-add-3 step of the binary to BCD conversion.
  function automatic logic [28:0] dabble_step(input logic [28:0] s);
    logic [28:0] t;
    t = s;
    for (int k = 0; k < 4; k++) begin
      if (t[13+4*k +: 4] >= 4'd5) t[13+4*k +: 4] = t[13+4*k +: 4] + 4'd3;
    end
    return {t[27:0], 1'b0};
  endfunction

  function automatic slot_t byte_slot(input logic [7:0] b);
    slot_t s;
    s.data = {120'b0, b};
    s.len  = 5'd1;
    return s;
  endfunction

  function automatic slot_t empty_slot();
    slot_t s;
    s.data = '0;
    s.len  = 5'd0;
    return s;
  endfunction

  // Decimal digits without leading zeros, most significant first.
  function automatic slot_t dec_slot(input logic [15:0] bcd);
    slot_t s;
    logic [7:0] c3, c2, c1, c0;
    c3 = {CH_DIGIT, bcd[15:12]};
    c2 = {CH_DIGIT, bcd[11:8]};
    c1 = {CH_DIGIT, bcd[7:4]};
    c0 = {CH_DIGIT, bcd[3:0]};
    s.data = '0;
    if (bcd[15:12] != 4'd0) begin
      s.data[31:0] = {c0, c1, c2, c3};
      s.len = 5'd4;
    end else if (bcd[11:8] != 4'd0) begin
      s.data[23:0] = {c0, c1, c2};
      s.len = 5'd3;
    end else if (bcd[7:4] != 4'd0) begin
      s.data[15:0] = {c0, c1};
      s.len = 5'd2;
    end else begin
      s.data[7:0] = c0;
      s.len = 5'd1;
    end
    return s;
  endfunction

  // A coordinate as a UTF-8 character of one to three bytes.
  function automatic slot_t utf8_slot(input logic [13:0] v);
    slot_t s;
    s.data = '0;
    if (v < 14'h0080) begin
      s.data[7:0] = v[7:0];
      s.len = 5'd1;
    end else if (v < 14'h0800) begin
      s.data[7:0]  = UTF8_LEAD2 | {3'b0, v[10:6]};
      s.data[15:8] = UTF8_CONT | {2'b0, v[5:0]};
      s.len = 5'd2;
    end else begin
      s.data[7:0]   = UTF8_LEAD3 | {6'b0, v[13:12]};
      s.data[15:8]  = UTF8_CONT | {2'b0, v[11:6]};
      s.data[23:16] = UTF8_CONT | {2'b0, v[5:0]};
      s.len = 5'd3;
    end
    return s;
  endfunction

  // A coordinate as one byte, saturated.
  function automatic slot_t x10_slot(input logic [13:0] v);
    return byte_slot((v > 14'd255) ? X10_SAT : v[7:0]);
  endfunction

  // Appends run b behind run a.
  function automatic slot_t merge_slots(input slot_t a, input slot_t b);
    slot_t s;
    s.data = a.data | (b.data << {a.len, 3'b000});
    s.len  = a.len + b.len;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic track_press_only_q, track_press_release_q, track_drag_q, track_any_motion_q;
  logic encode_utf8_q, encode_urxvt_q, encode_sgr_q;
  logic cfg_wr;
  logic rd_bit;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_press_only_q    <= 1'b0;
      track_press_release_q <= 1'b0;
      track_drag_q          <= 1'b0;
      track_any_motion_q    <= 1'b0;
      encode_utf8_q         <= 1'b0;
      encode_urxvt_q        <= 1'b0;
      encode_sgr_q          <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_TRACK_PRESS_ONLY:    track_press_only_q    <= pwdata[0];
        REG_TRACK_PRESS_RELEASE: track_press_release_q <= pwdata[0];
        REG_TRACK_DRAG:          track_drag_q          <= pwdata[0];
        REG_TRACK_ANY_MOTION:    track_any_motion_q    <= pwdata[0];
        REG_ENCODE_UTF8:         encode_utf8_q         <= pwdata[0];
        REG_ENCODE_URXVT:        encode_urxvt_q        <= pwdata[0];
        REG_ENCODE_SGR:          encode_sgr_q          <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[4:2])
      REG_TRACK_PRESS_ONLY:    rd_bit = track_press_only_q;
      REG_TRACK_PRESS_RELEASE: rd_bit = track_press_release_q;
      REG_TRACK_DRAG:          rd_bit = track_drag_q;
      REG_TRACK_ANY_MOTION:    rd_bit = track_any_motion_q;
      REG_ENCODE_UTF8:         rd_bit = encode_utf8_q;
      REG_ENCODE_URXVT:        rd_bit = encode_urxvt_q;
      REG_ENCODE_SGR:          rd_bit = encode_sgr_q;
      default:                 rd_bit = 1'b0;
    endcase
  end
  assign prdata = {{(DATA_W-1){1'b0}}, rd_bit};

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, ser_v_q;
  logic en1, en2, en3, en4, en5, en6, ser_take, ser_pop;
  logic [4:0] ser_cnt_q;

  assign ser_pop  = ser_v_q & rpt_o.ready;
  assign ser_take = !ser_v_q || (ser_pop && ser_cnt_q == 5'd1);
  assign en6 = !s6_v_q || ser_take;
  assign en5 = !s5_v_q || en6;
  assign en4 = !s4_v_q || en5;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign evt_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= evt_i.valid;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
      if (en4) s4_v_q <= s3_v_q;
      if (en5) s5_v_q <= s4_v_q;
      if (en6) s6_v_q <= s5_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: filter, button code and clamp
  // --------------------------------------------------------------------------
  s1_t s1_d, s1_q;

  always_comb begin
    logic press, rel, move;
    logic [5:0] bt;
    press = (evt_i.event_type == EV_PRESS);
    rel   = (evt_i.event_type == EV_RELEASE);
    move  = evt_i.event_type[1];
    bt    = {move, evt_i.ctrl_held, evt_i.meta_held, evt_i.shift_held, evt_i.button};

    s1_d.rep = track_any_motion_q
            || (track_drag_q && (press || rel || (move && evt_i.captured)))
            || (track_press_release_q && (press || rel))
            || (track_press_only_q && press);
    s1_d.release_evt = rel;
    if (encode_sgr_q)        s1_d.mode = ENC_SGR;
    else if (encode_urxvt_q) s1_d.mode = ENC_URXVT;
    else if (encode_utf8_q)  s1_d.mode = ENC_UTF8;
    else                     s1_d.mode = ENC_X10;
    // Outside SGR a release reads as button three and the code is offset.
    s1_d.bt_x10 = {1'b0, bt[5:2], bt[1:0] | {2{rel}}} + 7'd32;
    s1_d.bt_dec = encode_sgr_q ? {1'b0, bt} : s1_d.bt_x10;
    s1_d.row = clamp_pos(evt_i.row, evt_i.visible_rows);
    s1_d.col = clamp_pos(evt_i.col, evt_i.visible_cols);
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: button code to decimal, first seven coordinate steps
  // --------------------------------------------------------------------------
  s2_t s2_d, s2_q;

  always_comb begin
    logic [28:0] bacc, cacc, racc;
    bacc = {16'b0, s1_q.bt_dec, 6'b0};
    cacc = {16'b0, s1_q.col};
    racc = {16'b0, s1_q.row};
    for (int n = 0; n < 7; n++) begin
      bacc = dabble_step(bacc);
      cacc = dabble_step(cacc);
      racc = dabble_step(racc);
    end
    s2_d.rep         = s1_q.rep;
    s2_d.release_evt = s1_q.release_evt;
    s2_d.mode        = s1_q.mode;
    s2_d.bt_x10      = s1_q.bt_x10;
    s2_d.bt_bcd      = bacc[20:13];
    s2_d.col_acc     = cacc;
    s2_d.row_acc     = racc;
    s2_d.col         = s1_q.col;
    s2_d.row         = s1_q.row;
  end

  always_ff @(posedge clk_i) begin
    if (en2) s2_q <= s2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: remaining six coordinate steps
  // --------------------------------------------------------------------------
  s3_t s3_d, s3_q;

  always_comb begin
    logic [28:0] cacc, racc;
    cacc = s2_q.col_acc;
    racc = s2_q.row_acc;
    for (int n = 0; n < 6; n++) begin
      cacc = dabble_step(cacc);
      racc = dabble_step(racc);
    end
    s3_d.rep         = s2_q.rep;
    s3_d.release_evt = s2_q.release_evt;
    s3_d.mode        = s2_q.mode;
    s3_d.bt_x10      = s2_q.bt_x10;
    s3_d.bt_bcd      = s2_q.bt_bcd;
    s3_d.col_bcd     = cacc[28:13];
    s3_d.row_bcd     = racc[28:13];
    s3_d.col         = s2_q.col;
    s3_d.row         = s2_q.row;
  end

  always_ff @(posedge clk_i) begin
    if (en3) s3_q <= s3_d;
  end

  // --------------------------------------------------------------------------
  // Stage 4: build the report pieces and merge them in pairs
  // --------------------------------------------------------------------------
  s4_t s4_d, s4_q;

  always_comb begin
    slot_t sl0, sl1, sl2, sl3, sl4, sl5, sl6;
    logic dec;
    logic [13:0] c32, r32;
    dec = (s3_q.mode == ENC_SGR) || (s3_q.mode == ENC_URXVT);
    c32 = {1'b0, s3_q.col} + 14'd32;
    r32 = {1'b0, s3_q.row} + 14'd32;

    // Lead-in.
    sl0 = empty_slot();
    case (s3_q.mode)
      ENC_SGR: begin
        sl0.data[23:0] = {CH_LT, CH_LBRACK, CH_ESC};
        sl0.len = 5'd3;
      end
      ENC_URXVT: begin
        sl0.data[15:0] = {CH_LBRACK, CH_ESC};
        sl0.len = 5'd2;
      end
      default: begin
        sl0.data[23:0] = {CH_UP_M, CH_LBRACK, CH_ESC};
        sl0.len = 5'd3;
      end
    endcase

    // Button, separators and coordinates.
    sl1 = dec ? dec_slot({8'h00, s3_q.bt_bcd}) : byte_slot({1'b0, s3_q.bt_x10});
    sl2 = dec ? byte_slot(CH_SEMI) : empty_slot();
    sl4 = sl2;
    if (dec) begin
      sl3 = dec_slot(s3_q.col_bcd);
      sl5 = dec_slot(s3_q.row_bcd);
    end else if (s3_q.mode == ENC_UTF8) begin
      sl3 = utf8_slot(c32);
      sl5 = utf8_slot(r32);
    end else begin
      sl3 = x10_slot(c32);
      sl5 = x10_slot(r32);
    end

    // Final letter of the decimal forms.
    case (s3_q.mode)
      ENC_SGR:   sl6 = byte_slot(s3_q.release_evt ? CH_LO_M : CH_UP_M);
      ENC_URXVT: sl6 = byte_slot(CH_UP_M);
      default:   sl6 = empty_slot();
    endcase

    s4_d.rep = s3_q.rep;
    s4_d.p   = merge_slots(sl0, sl1);
    s4_d.q   = merge_slots(sl2, sl3);
    s4_d.r   = merge_slots(sl4, sl5);
    s4_d.t   = sl6;
  end

  always_ff @(posedge clk_i) begin
    if (en4) s4_q <= s4_d;
  end

  // --------------------------------------------------------------------------
  // Stage 5: merge into two halves
  // --------------------------------------------------------------------------
  s5_t s5_d, s5_q;

  always_comb begin
    s5_d.rep = s4_q.rep;
    s5_d.pq  = merge_slots(s4_q.p, s4_q.q);
    s5_d.rt  = merge_slots(s4_q.r, s4_q.t);
  end

  always_ff @(posedge clk_i) begin
    if (en5) s5_q <= s5_d;
  end

  // --------------------------------------------------------------------------
  // Stage 6: whole report, or a single zero byte for a filtered event
  // --------------------------------------------------------------------------
  s6_t s6_d, s6_q;

  always_comb begin
    s6_d.rep = s5_q.rep;
    if (s5_q.rep) s6_d.all = merge_slots(s5_q.pq, s5_q.rt);
    else          s6_d.all = byte_slot(8'h00);
  end

  always_ff @(posedge clk_i) begin
    if (en6) s6_q <= s6_d;
  end

  // --------------------------------------------------------------------------
  // Output serializer: one byte per item, lowest byte first
  // --------------------------------------------------------------------------
  logic [127:0] ser_data_q;
  logic         ser_rep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q   <= 1'b0;
      ser_cnt_q <= 5'd0;
    end else if (ser_take) begin
      ser_v_q   <= s6_v_q;
      ser_cnt_q <= s6_q.all.len;
    end else if (ser_pop) begin
      ser_cnt_q <= ser_cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_take) begin
      ser_data_q <= s6_q.all.data;
      ser_rep_q  <= s6_q.rep;
    end else if (ser_pop) begin
      ser_data_q <= {8'h00, ser_data_q[127:8]};
    end
  end

  assign rpt_o.valid    = ser_v_q;
  assign rpt_o.out_byte = ser_data_q[BYTE_W-1:0];
  assign rpt_o.reported = ser_rep_q;
  assign rpt_o.last     = (ser_cnt_q == 5'd1);

endmodule

/* tb/sv/mouse_report_encoder_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_report_encoder_core_test
// Self-checking bench for the mouse report encoder. Pointer events go in
// through the event channel while the tracking and encoding modes are set
// over the register port. A predictor builds the expected report bytes for
// each accepted event, and every byte that leaves the block is compared with
// the oldest expected byte. The run uses a directed set of corner events and
// then random events under random mode settings, with idle gaps on the event
// side and stalls on the report side.
// ----------------------------------------------------------------------------
module mouse_report_encoder_core_test;
  import mre_pkg::*;

  localparam int NUM_REGS      = 7;
  localparam int PIPE_SETTLE   = 10;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int PRINT_LIMIT   = 40;

  // Event kinds and buttons that the package leaves unnamed.
  localparam logic [1:0] EV_MOVE    = 2'd2;
  localparam logic [1:0] EV_ODD     = 2'd3;
  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_MIDDLE = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;
  localparam logic [1:0] BTN_NONE   = 2'd3;

  // Mode words, one bit per register.
  localparam logic [6:0] M_PRESS   = 7'd1 << REG_TRACK_PRESS_ONLY;
  localparam logic [6:0] M_PRESSREL = 7'd1 << REG_TRACK_PRESS_RELEASE;
  localparam logic [6:0] M_DRAG    = 7'd1 << REG_TRACK_DRAG;
  localparam logic [6:0] M_ANY     = 7'd1 << REG_TRACK_ANY_MOTION;
  localparam logic [6:0] M_UTF8    = 7'd1 << REG_ENCODE_UTF8;
  localparam logic [6:0] M_URXVT   = 7'd1 << REG_ENCODE_URXVT;
  localparam logic [6:0] M_SGR     = 7'd1 << REG_ENCODE_SGR;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_LONG
  } stall_e;

  typedef struct {
    logic [1:0]                kind;
    logic [1:0]                button;
    logic                      captured;
    logic signed [COORD_W-1:0] row;
    logic signed [COORD_W-1:0] col;
    logic                      shift;
    logic                      meta;
    logic                      ctrl;
    logic [COORD_W-1:0]        rows_vis;
    logic [COORD_W-1:0]        cols_vis;
  } mouse_event_t;

  typedef struct {
    logic [7:0] data;
    logic       reported;
    logic       last;
  } report_byte_t;

  // Predicts report bytes for accepted events and checks the bytes that leave.
  class report_tracker;
    logic [6:0]   modes;
    report_byte_t expected_bytes[$];
    logic [7:0]   seq[$];
    int unsigned  mismatches;
    int unsigned  events_seen;
    int unsigned  events_reported;
    int unsigned  bytes_checked;

    function new();
      modes = '0;
      mismatches = 0;
      events_seen = 0;
      events_reported = 0;
      bytes_checked = 0;
    endfunction

    // Clamps a position into the window and makes it one-based.
    function int unsigned clamp_coord(logic signed [COORD_W-1:0] p,
                                      logic [COORD_W-1:0] bound);
      int b;
      int q;
      b = bound;
      q = p;
      if (b > MAX_DIM) b = MAX_DIM;
      if (q >= b) q = b - 1;
      if (q < 0) q = 0;
      return q + 1;
    endfunction

    function void push_decimal(int unsigned v);
      logic [7:0] digits[$];
      do begin
        digits.push_front({CH_DIGIT, 4'(v % 10)});
        v = v / 10;
      end while (v != 0);
      foreach (digits[i]) seq.push_back(digits[i]);
    endfunction

    function void push_utf8(int unsigned c);
      if (c < 'h80) begin
        seq.push_back(8'(c));
      end else if (c < 'h800) begin
        seq.push_back(UTF8_LEAD2 | 8'(c >> 6));
        seq.push_back(UTF8_CONT | 8'(c & 'h3F));
      end else begin
        seq.push_back(UTF8_LEAD3 | 8'((c >> 12) & 'h0F));
        seq.push_back(UTF8_CONT | 8'((c >> 6) & 'h3F));
        seq.push_back(UTF8_CONT | 8'(c & 'h3F));
      end
    endfunction

    // Works out the report of one accepted event and queues its bytes.
    function void predict_report(mouse_event_t e);
      bit           press;
      bit           rel;
      bit           move;
      bit           rep;
      int unsigned  r;
      int unsigned  c;
      int unsigned  bt;
      report_byte_t b;
      press = (e.kind == EV_PRESS);
      rel   = (e.kind == EV_RELEASE);
      move  = !press && !rel;
      rep = modes[REG_TRACK_ANY_MOTION]
          || (modes[REG_TRACK_DRAG] && (press || rel || (move && e.captured)))
          || (modes[REG_TRACK_PRESS_RELEASE] && (press || rel))
          || (modes[REG_TRACK_PRESS_ONLY] && press);
      events_seen++;
      if (!rep) begin
        b.data = 8'h00;
        b.reported = 1'b0;
        b.last = 1'b1;
        expected_bytes.push_back(b);
      end else begin
        events_reported++;
        r = clamp_coord(e.row, e.rows_vis);
        c = clamp_coord(e.col, e.cols_vis);
        bt = e.button | (e.shift << 2) | (e.meta << 3) | (e.ctrl << 4) | (move << 5);
        seq.delete();
        seq.push_back(CH_ESC);
        seq.push_back(CH_LBRACK);
        if (modes[REG_ENCODE_SGR]) begin
          seq.push_back(CH_LT);
          push_decimal(bt);
          seq.push_back(CH_SEMI);
          push_decimal(c);
          seq.push_back(CH_SEMI);
          push_decimal(r);
          seq.push_back(rel ? CH_LO_M : CH_UP_M);
        end else begin
          // Legacy forms mark a release with button code three.
          if (rel) bt = bt | 3;
          bt = bt + 32;
          if (modes[REG_ENCODE_URXVT]) begin
            push_decimal(bt);
            seq.push_back(CH_SEMI);
            push_decimal(c);
            seq.push_back(CH_SEMI);
            push_decimal(r);
            seq.push_back(CH_UP_M);
          end else begin
            r = r + 32;
            c = c + 32;
            seq.push_back(CH_UP_M);
            seq.push_back(8'(bt));
            if (modes[REG_ENCODE_UTF8]) begin
              push_utf8(c);
              push_utf8(r);
            end else begin
              seq.push_back(c > 255 ? X10_SAT : 8'(c));
              seq.push_back(r > 255 ? X10_SAT : 8'(r));
            end
          end
        end
        foreach (seq[i]) begin
          b.data = seq[i];
          b.reported = 1'b1;
          b.last = (i == seq.size() - 1);
          expected_bytes.push_back(b);
        end
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Compares one byte leaving the block with the oldest expected byte.
    task check_byte(report_byte_t got);
      report_byte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %02h arrived with nothing expected", got.data));
      end else begin
        want = expected_bytes.pop_front();
        if (got.data !== want.data)
          report($sformatf("byte %0d: out_byte %02h, expected %02h",
                           bytes_checked, got.data, want.data));
        if (got.reported !== want.reported)
          report($sformatf("byte %0d: reported %b, expected %b",
                           bytes_checked, got.reported, want.reported));
        if (got.last !== want.last)
          report($sformatf("byte %0d: last %b, expected %b",
                           bytes_checked, got.last, want.last));
        bytes_checked++;
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mre_evt_if evt ();
  mre_rpt_if rpt ();

  report_tracker tracker = new();

  int unsigned cycle_count;
  int unsigned mode_settings;
  int          burst_left;
  bit          steady_sender;

  mouse_report_encoder_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt),
    .rpt_o   (rpt),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // Report side: ready follows a randomly chosen stall style, redrawn when its run ends.
  initial begin
    int     style_cycles;
    stall_e style;
    style_cycles = 0;
    style = STALL_NONE;
    rpt.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (style_cycles == 0) begin
        style = stall_e'($urandom_range(0, 3));
        style_cycles = $urandom_range(20, 80);
      end
      style_cycles--;
      case (style)
        STALL_NONE:     rpt.ready <= 1'b1;
        STALL_RANDOM:   rpt.ready <= 1'($urandom_range(0, 1));
        STALL_PERIODIC: rpt.ready <= (style_cycles % 3) != 0;
        default:        rpt.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Every byte accepted on the report side is checked.
  always @(posedge clk_i) begin
    report_byte_t seen;
    if (rst_ni && rpt.valid && rpt.ready) begin
      seen.data = rpt.out_byte;
      seen.reported = rpt.reported;
      seen.last = rpt.last;
      tracker.check_byte(seen);
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("Timed out after %0d cycles with %0d bytes outstanding.",
             cycle_count, tracker.expected_bytes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic mouse_event_t mk_event(
      logic [1:0] kind, logic [1:0] button, logic captured,
      int row, int col, logic shift, logic meta, logic ctrl,
      int rows_vis, int cols_vis);
    mouse_event_t e;
    e.kind = kind;
    e.button = button;
    e.captured = captured;
    e.row = COORD_W'(row);
    e.col = COORD_W'(col);
    e.shift = shift;
    e.meta = meta;
    e.ctrl = ctrl;
    e.rows_vis = COORD_W'(rows_vis);
    e.cols_vis = COORD_W'(cols_vis);
    return e;
  endfunction

  // Mostly small windows with the pointer near them, some wide windows, and
  // some fully random coordinates and sizes.
  function automatic mouse_event_t rand_event();
    mouse_event_t e;
    int           pick;
    int           rv;
    int           cv;
    e.kind = 2'($urandom_range(0, 3));
    e.button = 2'($urandom_range(0, 3));
    e.captured = 1'($urandom_range(0, 1));
    e.shift = 1'($urandom_range(0, 1));
    e.meta = 1'($urandom_range(0, 1));
    e.ctrl = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      rv = $urandom_range(1, 80);
      cv = $urandom_range(1, 250);
      e.rows_vis = COORD_W'(rv);
      e.cols_vis = COORD_W'(cv);
      e.row = COORD_W'(int'($urandom_range(0, rv + 3)) - 2);
      e.col = COORD_W'(int'($urandom_range(0, cv + 3)) - 2);
    end else if (pick < 8) begin
      rv = $urandom_range(1000, 8191);
      cv = $urandom_range(1000, 8191);
      e.rows_vis = COORD_W'(rv);
      e.cols_vis = COORD_W'(cv);
      e.row = COORD_W'($urandom_range(0, 4095));
      e.col = COORD_W'($urandom_range(0, 4095));
    end else begin
      e.rows_vis = COORD_W'($urandom);
      e.cols_vis = COORD_W'($urandom);
      e.row = COORD_W'($urandom);
      e.col = COORD_W'($urandom);
    end
    return e;
  endfunction

  // One register access; entered and left at a falling edge.
  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic hold_sender();
    evt.valid <= 1'b0;
  endtask

  // Stops sending and waits until every expected byte has come out.
  task automatic wait_for_reports();
    hold_sender();
    while (tracker.expected_bytes.size() != 0) @(negedge clk_i);
  endtask

  // Writes all mode registers while the block is idle and reads each back.
  task automatic set_modes(input logic [6:0] modes);
    logic [DATA_W-1:0] readback;
    logic [2:0]        idx;
    wait_for_reports();
    repeat (PIPE_SETTLE) @(negedge clk_i);
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = 3'(i);
      apb_access(1'b1, idx, DATA_W'(modes[idx]), readback);
      tracker.modes[idx] = modes[idx];
      apb_access(1'b0, idx, '0, readback);
      if (readback !== DATA_W'(modes[idx]))
        tracker.report($sformatf("register %0d reads %08h, expected %0d",
                                 idx, readback, modes[idx]));
    end
    mode_settings++;
  endtask

  // Bursts of back-to-back events, separated by idle gaps unless steady.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (!steady_sender) begin
        gap = $urandom_range(1, 6);
        hold_sender();
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Sends one event; entered and left at a falling edge.
  task automatic send_event(input mouse_event_t e);
    evt.event_type <= e.kind;
    evt.button <= e.button;
    evt.captured <= e.captured;
    evt.row <= e.row;
    evt.col <= e.col;
    evt.shift_held <= e.shift;
    evt.meta_held <= e.meta;
    evt.ctrl_held <= e.ctrl;
    evt.visible_rows <= e.rows_vis;
    evt.visible_cols <= e.cols_vis;
    evt.valid <= 1'b1;
    do @(posedge clk_i); while (!evt.ready);
    tracker.predict_report(e);
    @(negedge clk_i);
    pace_sender();
  endtask

  initial begin
    logic [6:0] modes;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    evt.valid = 1'b0;
    evt.event_type = EV_PRESS;
    evt.button = BTN_LEFT;
    evt.captured = 1'b0;
    evt.row = '0;
    evt.col = '0;
    evt.shift_held = 1'b0;
    evt.meta_held = 1'b0;
    evt.ctrl_held = 1'b0;
    evt.visible_rows = '0;
    evt.visible_cols = '0;
    mode_settings = 0;
    burst_left = 0;
    steady_sender = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // No tracking mode: the event is filtered.
    set_modes('0);
    send_event(mk_event(EV_PRESS, BTN_LEFT, 0, 5, 5, 0, 0, 0, 24, 80));

    // SGR with every field at an extreme; oversized window saturates the bound.
    set_modes(M_ANY | M_SGR);
    send_event(mk_event(EV_PRESS, BTN_NONE, 1, 4095, 4095, 1, 1, 1, 8191, 8191));
    send_event(mk_event(EV_RELEASE, BTN_LEFT, 0, -4096, -4096, 0, 0, 0, 0, 0));
    send_event(mk_event(EV_MOVE, BTN_RIGHT, 1, 12, 40, 0, 1, 0, 24, 80));
    send_event(mk_event(EV_ODD, BTN_MIDDLE, 0, 30, 100, 1, 0, 1, 24, 80));

    // urxvt wins over UTF-8.
    set_modes(M_ANY | M_URXVT | M_UTF8);
    send_event(mk_event(EV_PRESS, BTN_MIDDLE, 0, 10, 200, 0, 0, 0, 50, 300));
    send_event(mk_event(EV_RELEASE, BTN_RIGHT, 0, 7, 9, 1, 1, 1, 50, 300));

    // UTF-8 coordinates of one, two and three bytes.
    set_modes(M_ANY | M_UTF8);
    send_event(mk_event(EV_PRESS, BTN_LEFT, 0, 10, 50, 0, 0, 0, 24, 80));
    send_event(mk_event(EV_PRESS, BTN_RIGHT, 0, 500, 90, 1, 0, 0, 1000, 1000));
    send_event(mk_event(EV_PRESS, BTN_LEFT, 0, 3000, 4095, 0, 0, 1, 4096, 4096));
    send_event(mk_event(EV_MOVE, BTN_NONE, 0, 2100, 2015, 0, 1, 0, 4096, 4096));

    // X10 saturates coordinates at 255.
    set_modes(M_ANY);
    send_event(mk_event(EV_PRESS, BTN_LEFT, 0, 5, 300, 0, 0, 0, 400, 400));
    send_event(mk_event(EV_RELEASE, BTN_MIDDLE, 0, 4095, 0, 0, 1, 0, 8191, 8191));
    send_event(mk_event(EV_ODD, BTN_NONE, 1, 3, 3, 1, 1, 1, 10, 10));

    // Press-only tracking.
    set_modes(M_PRESS);
    send_event(mk_event(EV_PRESS, BTN_RIGHT, 0, 1, 1, 0, 0, 0, 24, 80));
    send_event(mk_event(EV_RELEASE, BTN_RIGHT, 0, 1, 1, 0, 0, 0, 24, 80));
    send_event(mk_event(EV_MOVE, BTN_NONE, 1, 1, 1, 0, 0, 0, 24, 80));

    // Press and release tracking.
    set_modes(M_PRESSREL | M_URXVT);
    send_event(mk_event(EV_RELEASE, BTN_LEFT, 0, 20, 70, 0, 0, 0, 24, 80));
    send_event(mk_event(EV_MOVE, BTN_LEFT, 1, 20, 70, 0, 0, 0, 24, 80));

    // Drag tracking reports moves only while captured.
    set_modes(M_DRAG | M_SGR);
    send_event(mk_event(EV_MOVE, BTN_LEFT, 1, 15, 60, 0, 0, 0, 24, 80));
    send_event(mk_event(EV_MOVE, BTN_LEFT, 0, 15, 60, 0, 0, 0, 24, 80));
    send_event(mk_event(EV_ODD, BTN_NONE, 1, 15, 60, 0, 0, 0, 24, 80));

    // Random events under random modes, the first setting with every bit set.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        modes = '1;
      end else begin
        modes = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 1)) modes[REG_TRACK_ANY_MOTION] = 1'b1;
      end
      set_modes(modes);
      steady_sender = (phase % 3 == 1);
      for (int n = 0; n < 10; n++) begin
        if (phase == 4 && n == 6) wait_for_reports();
        send_event(rand_event());
      end
    end

    wait_for_reports();
    repeat (PIPE_SETTLE) @(negedge clk_i);

    $display("Covered %0d events (%0d reported, %0d filtered), %0d report bytes,",
             tracker.events_seen, tracker.events_reported,
             tracker.events_seen - tracker.events_reported, tracker.bytes_checked);
    $display("over %0d mode settings; %0d mismatches.", mode_settings,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
